@@ rtl/wam_pkg.sv @@
package wam_pkg;

  // Field widths of the command and result words
  localparam int VTX_W    = 6;
  localparam int WEIGHT_W = 16;
  localparam int STATUS_W = 2;

  // Default graph size
  localparam int VERTICES_DEF = 8;

  // Command kinds
  localparam logic KIND_LIST   = 1'b0;
  localparam logic KIND_MODIFY = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ENTRY = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

  // Command word
  typedef struct packed {
    logic                kind;
    logic [VTX_W-1:0]    vertex_a;
    logic [VTX_W-1:0]    vertex_b;
    logic [WEIGHT_W-1:0] edge_weight;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VTX_W-1:0]    neighbour;
    logic [WEIGHT_W-1:0] neighbour_weight;
    logic                last;
  } out_word_t;

endpackage

@@ rtl/weighted_adjacency_matrix_store.sv @@
// Weighted undirected graph store. A command word is taken when start is high
// and busy is low. A modify command reads the cell, writes it, then writes its
// mirror, and gives one done or error word; a list command walks the row
// through the weight RAM's single read port one column per cycle, and gives
// one word per neighbour in ascending order, then a done word. Range errors and
// deletes of absent edges give one error word. Each result word is on out_data
// for exactly one cycle with out_valid high, and the receiver cannot stall: it
// must take every word as it comes. After reset the weight RAM is cleared one
// cell a cycle, all 4**clog2(VERTICES) cells (64 at the default size), and busy
// stays high until the clearing pass ends.
module weighted_adjacency_matrix_store
  import wam_pkg::*;
#(
  parameter int VERTICES = VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_valid,
  output out_word_t out_data
);

  localparam int VW = $clog2(VERTICES);
  localparam int AW = 2 * VW;
  localparam logic [VTX_W-1:0] VMAX     = VTX_W'(VERTICES);
  localparam logic [VW-1:0]    LAST_COL = VW'(VERTICES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_END   = 3'd3;
  localparam logic [2:0] S_MCHK  = 3'd4;
  localparam logic [2:0] S_MWR2  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [VW-1:0]       row_r, row_nxt;
  logic [VW-1:0]       colb_r, colb_nxt;
  logic [VW-1:0]       col_r, col_nxt;
  logic [WEIGHT_W-1:0] w_r, w_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_data_r, out_data_nxt;

  logic                accept;
  logic                a_ok, b_ok;
  logic [VTX_W-1:0]    a_m1, b_m1;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [WEIGHT_W-1:0] mem_wdata, mem_rdata;
  logic                cell_nz;

  wam_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Vertex range checks and zero-based indexes
  assign a_ok    = (in_data.vertex_a != '0) && (in_data.vertex_a <= VMAX);
  assign b_ok    = (in_data.vertex_b != '0) && (in_data.vertex_b <= VMAX);
  assign a_m1    = in_data.vertex_a - VTX_W'(1);
  assign b_m1    = in_data.vertex_b - VTX_W'(1);
  assign cell_nz = (mem_rdata != '0);

  // Read address: from the command when idle, next column while scanning
  always_comb begin
    if (state_r == S_IDLE) begin
      if (in_data.kind == KIND_LIST) begin
        mem_raddr = {a_m1[VW-1:0], {VW{1'b0}}};
      end else begin
        mem_raddr = {a_m1[VW-1:0], b_m1[VW-1:0]};
      end
    end else begin
      mem_raddr = {row_r, col_r + VW'(1)};
    end
  end

  // Write port: clearing pass, cell a-b, then its mirror b-a
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {row_r, colb_r};
    mem_wdata = w_r;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      S_MCHK: begin
        mem_we = (w_r != '0) || cell_nz;
      end
      S_MWR2: begin
        mem_we    = 1'b1;
        mem_waddr = {colb_r, row_r};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    row_nxt       = row_r;
    colb_nxt      = colb_r;
    col_nxt       = col_r;
    w_nxt         = w_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          row_nxt  = a_m1[VW-1:0];
          colb_nxt = b_m1[VW-1:0];
          col_nxt  = '0;
          w_nxt    = in_data.edge_weight;
          if (!a_ok || (in_data.kind == KIND_MODIFY && !b_ok)) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{ST_ERROR, '0, '0, 1'b1};
          end else if (in_data.kind == KIND_LIST) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_MCHK;
          end
        end
      end
      S_SCAN: begin
        // Data for col_r is here; one neighbour word per nonzero cell
        if (cell_nz) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{ST_ENTRY, VTX_W'(col_r) + VTX_W'(1), mem_rdata, 1'b0};
        end
        col_nxt = col_r + VW'(1);
        if (col_r == LAST_COL) begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{ST_DONE, '0, '0, 1'b1};
        col_nxt       = '0;
        state_nxt     = S_IDLE;
      end
      S_MCHK: begin
        // Deleting an absent edge is an error; nothing is written
        if (w_r == '0 && !cell_nz) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{ST_ERROR, '0, '0, 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_MWR2;
        end
      end
      S_MWR2: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{ST_DONE, '0, '0, 1'b1};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    colb_r     <= colb_nxt;
    w_r        <= w_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A neighbour word never closes a command and always names a vertex
  a_entry_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_ENTRY |-> !out_data.last && out_data.neighbour != '0)
    else $error("neighbour word malformed");

  // Done and error words close a command with empty fields
  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_ENTRY
      |-> out_data.last && out_data.neighbour == '0 && out_data.neighbour_weight == '0)
    else $error("closing word malformed");

  // The RAM is only written while no command can be taken
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> busy)
    else $error("weight RAM written while idle");

  // A valid list command keeps the block busy next cycle
  a_list_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.kind == KIND_LIST && a_ok |=> busy && !out_valid)
    else $error("list command did not start a scan");

endmodule

@@ rtl/wam_mem.sv @@
module wam_mem
  import wam_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [WEIGHT_W-1:0] wdata,
  input  logic [AW-1:0]       raddr,
  output logic [WEIGHT_W-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [WEIGHT_W-1:0] mem [DEPTH];
  logic [WEIGHT_W-1:0] rdata_r;

  // Single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import wam_pkg::*;

  localparam int NV         = VERTICES_DEF;
  localparam int CYCLE_CAP  = 50000;
  localparam int TAIL_WAIT  = NV + 6;
  localparam int PHASE_ITEMS = 29;

  // One row of the directed table: the command word, and optionally a
  // single typed-in result status (last set, other fields zero)
  typedef struct {
    in_word_t   word;
    bit         typed;
    logic [1:0] status;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_data;
  logic      out_valid;
  out_word_t out_data;

  // Shadow copy of the weight matrix, indexed from zero
  logic [WEIGHT_W-1:0] graph_w [NV][NV];

  out_word_t result_q[$];     // words the block should still emit
  out_word_t scratch_q[$];    // words caused by the command just taken

  bit         row_typed;
  logic [1:0] row_status;

  int fail_count;
  int words_taken;
  int list_count;
  int modify_count;
  int entry_seen;
  int error_seen;
  int cycle_count;

  dir_row_t dir_rows[$];
  int       idle_set[3] = '{0, 57, 8};

  weighted_adjacency_matrix_store #(
    .VERTICES(NV)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic bit vertex_in_range(logic [VTX_W-1:0] v);
    return (v >= 1) && (v <= NV);
  endfunction

  function automatic out_word_t make_word(logic [1:0] st, int nb, logic [WEIGHT_W-1:0] w,
                                          logic lst);
    out_word_t r;
    r.status           = st;
    r.neighbour        = VTX_W'(nb);
    r.neighbour_weight = w;
    r.last             = lst;
    return r;
  endfunction

  // Graph predictor: updates the shadow matrix, leaves the caused words in scratch_q
  function automatic void graph_apply(in_word_t w);
    int ia;
    int ib;
    scratch_q.delete();
    if (w.kind == KIND_LIST) begin
      if (!vertex_in_range(w.vertex_a)) begin
        scratch_q.push_back(make_word(ST_ERROR, 0, '0, 1'b1));
        return;
      end
      ia = int'(w.vertex_a) - 1;
      for (int c = 0; c < NV; c++) begin
        if (graph_w[ia][c] != 0)
          scratch_q.push_back(make_word(ST_ENTRY, c + 1, graph_w[ia][c], 1'b0));
      end
      scratch_q.push_back(make_word(ST_DONE, 0, '0, 1'b1));
      return;
    end
    if (!vertex_in_range(w.vertex_a) || !vertex_in_range(w.vertex_b)) begin
      scratch_q.push_back(make_word(ST_ERROR, 0, '0, 1'b1));
      return;
    end
    ia = int'(w.vertex_a) - 1;
    ib = int'(w.vertex_b) - 1;
    // deleting an edge that is not there
    if (w.edge_weight == 0 && graph_w[ia][ib] == 0) begin
      scratch_q.push_back(make_word(ST_ERROR, 0, '0, 1'b1));
      return;
    end
    graph_w[ia][ib] = w.edge_weight;
    graph_w[ib][ia] = w.edge_weight;
    scratch_q.push_back(make_word(ST_DONE, 0, '0, 1'b1));
  endfunction

  function automatic void check_word(out_word_t want, out_word_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fail_count++;
    end
    if (got.neighbour !== want.neighbour) begin
      $error("neighbour: expected %0d, got %0d", want.neighbour, got.neighbour);
      fail_count++;
    end
    if (got.neighbour_weight !== want.neighbour_weight) begin
      $error("neighbour_weight: expected %0h, got %0h", want.neighbour_weight,
             got.neighbour_weight);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      fail_count++;
    end
  endfunction

  function automatic dir_row_t dir_row(logic kind, int a, int b, int w, bit typed,
                                       logic [1:0] st);
    dir_row_t r;
    r.word.kind        = kind;
    r.word.vertex_a    = VTX_W'(a);
    r.word.vertex_b    = VTX_W'(b);
    r.word.edge_weight = WEIGHT_W'(w);
    r.typed            = typed;
    r.status           = st;
    return r;
  endfunction

  // Mostly in-range commands; a tenth is fully random noise
  function automatic in_word_t random_word();
    in_word_t w;
    int       r;
    int       tries;
    w.kind        = 1'($urandom);
    w.vertex_a    = VTX_W'($urandom);
    w.vertex_b    = VTX_W'($urandom);
    w.edge_weight = WEIGHT_W'($urandom);
    r = $urandom_range(99);
    if (r < 10) return w;
    w.vertex_a = VTX_W'($urandom_range(NV, 1));
    if (r < 45) begin
      w.kind = KIND_LIST;
      return w;
    end
    w.kind     = KIND_MODIFY;
    w.vertex_b = VTX_W'($urandom_range(NV, 1));
    r = $urandom_range(99);
    if (r < 25) begin
      // delete: try to land on an edge that exists
      w.edge_weight = '0;
      tries = 0;
      while (tries < 8 && graph_w[w.vertex_a - 1][w.vertex_b - 1] == 0) begin
        w.vertex_a = VTX_W'($urandom_range(NV, 1));
        w.vertex_b = VTX_W'($urandom_range(NV, 1));
        tries++;
      end
    end else if (r < 35) begin
      w.edge_weight = 16'hFFFF;
    end else if (r < 65) begin
      w.edge_weight = WEIGHT_W'($urandom_range(255, 1));
    end else begin
      w.edge_weight = WEIGHT_W'($urandom_range(65535, 1));
    end
    return w;
  endfunction

  // Drive one command word at the falling edge, hold it until taken
  task automatic send_word(in_word_t w, bit typed, logic [1:0] st, int idle_pct);
    int taken;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start      = 1'b1;
    in_data    = w;
    row_typed  = typed;
    row_status = st;
    taken      = words_taken;
    do @(negedge clk); while (words_taken == taken);
  endtask

  // Result check and command capture, both on the rising edge
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (out_data.status == ST_ENTRY) entry_seen++;
        if (out_data.status == ST_ERROR) error_seen++;
        if (result_q.size() == 0) begin
          $error("result word %h with nothing expected", out_data);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          check_word(want, out_data);
        end
      end
      if (start && !busy) begin
        graph_apply(in_data);
        if (row_typed) begin
          result_q.push_back(make_word(row_status, 0, '0, 1'b1));
        end else begin
          foreach (scratch_q[i]) result_q.push_back(scratch_q[i]);
        end
        if (in_data.kind == KIND_LIST) list_count++;
        else modify_count++;
        words_taken++;
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < NV; r++)
      for (int c = 0; c < NV; c++)
        graph_w[r][c] = '0;
    fail_count   = 0;
    words_taken  = 0;
    list_count   = 0;
    modify_count = 0;
    entry_seen   = 0;
    error_seen   = 0;
    cycle_count  = 0;
    row_typed    = 1'b0;
    row_status   = ST_ENTRY;
    start        = 1'b0;
    in_data      = '0;
    rst_n        = 1'b0;

    // Directed table
    dir_rows.push_back(dir_row(KIND_LIST,    1,  0, 0,       1, ST_DONE));   // empty graph
    dir_rows.push_back(dir_row(KIND_LIST,    0,  0, 0,       1, ST_ERROR));
    dir_rows.push_back(dir_row(KIND_LIST,    63, 63, 'hFFFF, 1, ST_ERROR));
    dir_rows.push_back(dir_row(KIND_LIST,    NV + 1, 1, 0,   1, ST_ERROR));
    dir_rows.push_back(dir_row(KIND_MODIFY,  0,  1, 5,       1, ST_ERROR));
    dir_rows.push_back(dir_row(KIND_MODIFY,  1,  NV + 1, 5,  1, ST_ERROR));
    dir_rows.push_back(dir_row(KIND_MODIFY,  63, 63, 'hFFFF, 1, ST_ERROR));
    dir_rows.push_back(dir_row(KIND_MODIFY,  1,  2, 0,       1, ST_ERROR));  // absent delete
    dir_rows.push_back(dir_row(KIND_MODIFY,  1,  NV, 'hFFFF, 1, ST_DONE));
    dir_rows.push_back(dir_row(KIND_MODIFY,  1,  1, 1,       1, ST_DONE));   // self-loop
    dir_rows.push_back(dir_row(KIND_MODIFY,  NV, NV, 'h8000, 1, ST_DONE));
    dir_rows.push_back(dir_row(KIND_LIST,    1,  0, 0,       0, ST_ENTRY));
    dir_rows.push_back(dir_row(KIND_LIST,    NV, 0, 0,       0, ST_ENTRY));
    dir_rows.push_back(dir_row(KIND_MODIFY,  2,  1, 'h1234,  1, ST_DONE));
    dir_rows.push_back(dir_row(KIND_MODIFY,  1,  2, 'h5678,  1, ST_DONE));   // update
    dir_rows.push_back(dir_row(KIND_LIST,    2,  0, 0,       0, ST_ENTRY));
    dir_rows.push_back(dir_row(KIND_MODIFY,  2,  1, 0,       1, ST_DONE));   // delete
    dir_rows.push_back(dir_row(KIND_MODIFY,  1,  2, 0,       1, ST_ERROR));
    dir_rows.push_back(dir_row(KIND_MODIFY,  1,  1, 0,       1, ST_DONE));
    dir_rows.push_back(dir_row(KIND_LIST,    1,  0, 0,       0, ST_ENTRY));
    dir_rows.push_back(dir_row(KIND_LIST,    NV, 63, 'hFFFF, 0, ST_ENTRY));  // b ignored
    dir_rows.push_back(dir_row(KIND_MODIFY,  NV, 1, 0,       1, ST_DONE));
    dir_rows.push_back(dir_row(KIND_LIST,    NV, 0, 0,       0, ST_ENTRY));

    // Synchronous reset, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].status, 0);

    // Random part, one phase per sender idle setting
    foreach (idle_set[p])
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_word(random_word(), 1'b0, ST_ENTRY, idle_set[p]);
    start = 1'b0;

    // Drain, then let a list scan's worth of cycles pass
    while (result_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Ran %0d command words (%0d list, %0d modify) at sender idle 0/57/8 percent.",
             words_taken, list_count, modify_count);
    $display("Saw %0d neighbour words and %0d error words; %0d field mismatches.",
             entry_seen, error_seen, fail_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
